### sv/nafir_pkg.sv
// shared types, constants and q15 helper functions for the nlms adaptive fir
`default_nettype none
package nafir_pkg;

    localparam int Q15_FRAC  = 15;
    localparam int DIV_STEPS = 15;

    localparam logic [1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd1;
    localparam logic [1:0] CFG_NORMALIZE     = 2'd2;

    localparam logic [6:0]  RST_TAP_COUNT     = 7'd64;
    localparam logic [14:0] RST_LEARNING_RATE = 15'h0003;
    localparam logic        RST_NORMALIZE     = 1'b1;

    localparam logic OP_ADAPT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] sample;
        logic signed [15:0] desired;
        logic [5:0]         tap_index;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] filter_output;
        logic signed [15:0] error_out;
        logic signed [15:0] tap_value;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUSH,
        S_ARD,
        S_AMUL,
        S_AADD,
        S_ERR,
        S_URD,
        S_UM1,
        S_UM2,
        S_DIVI,
        S_DIV,
        S_UWR,
        S_ADONE,
        S_RRD,
        S_RDONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load_in;
        logic push;
        logic mul;
        logic acc;
        logic err;
        logic um1;
        logic um2;
        logic div_init;
        logic div_step;
        logic uwr;
        logic sel_tap;
        logic out_adapt;
        logic out_read;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic k_done;
        logic div_last;
        logic out_busy;
        logic normalize;
    } t_sts;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // q15 product, floor toward minus infinity, saturated
    function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [31:0] p;
        p = a * b;
        return sat16(p >>> Q15_FRAC);
    endfunction

endpackage
`default_nettype wire

### sv/nafir_ctrl.sv
// sequencer for the nlms adaptive fir: clear pass, filter pass, update pass, tap read
`default_nettype none
module nafir_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_op,
    input  nafir_pkg::t_sts   i_sts,
    output nafir_pkg::t_cmd   o_cmd,
    output logic              o_busy
);

    nafir_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nafir_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            nafir_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = nafir_pkg::S_IDLE;
            end
            nafir_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_in_op == nafir_pkg::OP_READ) ? nafir_pkg::S_RRD
                                                              : nafir_pkg::S_PUSH;
                end
            end
            nafir_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = nafir_pkg::S_ARD;
            end
            nafir_pkg::S_ARD: begin
                n_state = i_sts.k_done ? nafir_pkg::S_ERR : nafir_pkg::S_AMUL;
            end
            nafir_pkg::S_AMUL: begin
                o_cmd.mul = 1'b1;
                n_state = nafir_pkg::S_AADD;
            end
            nafir_pkg::S_AADD: begin
                o_cmd.acc = 1'b1;
                n_state = nafir_pkg::S_ARD;
            end
            nafir_pkg::S_ERR: begin
                o_cmd.err = 1'b1;
                n_state = nafir_pkg::S_URD;
            end
            nafir_pkg::S_URD: begin
                n_state = i_sts.k_done ? nafir_pkg::S_ADONE : nafir_pkg::S_UM1;
            end
            nafir_pkg::S_UM1: begin
                o_cmd.um1 = 1'b1;
                n_state = nafir_pkg::S_UM2;
            end
            nafir_pkg::S_UM2: begin
                o_cmd.um2 = 1'b1;
                n_state = i_sts.normalize ? nafir_pkg::S_DIVI : nafir_pkg::S_UWR;
            end
            nafir_pkg::S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = nafir_pkg::S_DIV;
            end
            nafir_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = nafir_pkg::S_UWR;
            end
            nafir_pkg::S_UWR: begin
                o_cmd.uwr = 1'b1;
                n_state = nafir_pkg::S_URD;
            end
            nafir_pkg::S_ADONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_adapt = 1'b1;
                    n_state = nafir_pkg::S_IDLE;
                end
            end
            nafir_pkg::S_RRD: begin
                o_cmd.sel_tap = 1'b1;
                n_state = nafir_pkg::S_RDONE;
            end
            nafir_pkg::S_RDONE: begin
                o_cmd.sel_tap = 1'b1;
                if (!i_sts.out_busy) begin
                    o_cmd.out_read = 1'b1;
                    n_state = nafir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nafir_pkg::S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/nafir_dpath.sv
// datapath: tap memories, mac unit, serial divider, config and result registers
`default_nettype none
module nafir_dpath #(
    parameter int TAPS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  nafir_pkg::t_cmd      i_cmd,
    output nafir_pkg::t_sts      o_sts,
    input  nafir_pkg::t_in_item  i_in_data,
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_idx,
    input  wire [14:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output nafir_pkg::t_out_item o_out_data
);

    localparam int AW   = $clog2(TAPS);
    localparam int CW   = $clog2(TAPS + 1);
    localparam int ACCW = 17 + CW;

    logic [15:0] dl_mem [TAPS];
    logic [15:0] cf_mem [TAPS];

    logic [6:0]  r_tap_count;
    logic [14:0] r_rate;
    logic        r_norm;

    logic signed [15:0] r_x, r_d;
    logic [5:0]         r_idx;
    logic [CW-1:0]      r_n, r_k;
    logic [AW-1:0]      r_b;
    logic signed [15:0] r_dq, r_cq;
    logic signed [15:0] r_py, r_pe;
    logic signed [ACCW-1:0] r_acc_y, r_acc_e;
    logic signed [15:0] r_y, r_e, r_en;
    logic signed [15:0] r_p1, r_upd;
    logic [16:0]        r_rem;
    logic [14:0]        r_q;
    logic [3:0]         r_dc;
    logic               r_sgn, r_sat;
    logic               r_out_vld;
    nafir_pkg::t_out_item r_out;

    logic [AW:0]        dl_sum;
    logic [AW-1:0]      dl_addr, cf_addr, b_dec;
    logic [CW-1:0]      n_clamp;
    logic               idx_ok;
    logic signed [15:0] y_sat, e_sat, en_sat, upd_fin, cf_new;
    logic signed [16:0] upd_ext;
    logic [16:0]        upd_abs, rem_sh;

    // delay line is circular: entry k sits at base + k
    always_comb begin
        dl_sum  = {1'b0, r_b} + {1'b0, r_k[AW-1:0]};
        dl_addr = (dl_sum >= (AW+1)'(TAPS)) ? AW'(dl_sum - (AW+1)'(TAPS)) : dl_sum[AW-1:0];
        cf_addr = i_cmd.sel_tap ? AW'(r_idx) : r_k[AW-1:0];
        b_dec   = (r_b == '0) ? AW'(TAPS - 1) : r_b - 1'b1;
        idx_ok  = (32'(r_idx) < TAPS);
        if (i_in_data.op == nafir_pkg::OP_READ || r_tap_count == '0) begin
            n_clamp = CW'(1);
        end else if (32'(r_tap_count) > TAPS) begin
            n_clamp = CW'(TAPS);
        end else begin
            n_clamp = CW'(r_tap_count);
        end
        y_sat   = nafir_pkg::sat16(32'(r_acc_y));
        e_sat   = nafir_pkg::sat16(32'(r_d) - 32'(y_sat));
        en_sat  = nafir_pkg::sat16(32'(r_acc_e));
        upd_ext = {r_upd[15], r_upd};
        upd_abs = upd_ext[16] ? 17'(-upd_ext) : 17'(upd_ext);
        rem_sh  = {r_rem[15:0], 1'b0};
        if (!r_norm) begin
            upd_fin = r_upd;
        end else if (r_sat) begin
            upd_fin = r_sgn ? 16'sh8000 : 16'sh7FFF;
        end else begin
            upd_fin = r_sgn ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
        cf_new  = nafir_pkg::sat16(32'(r_cq) + 32'(upd_fin));
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            dl_mem[r_k[AW-1:0]] <= '0;
            cf_mem[r_k[AW-1:0]] <= '0;
        end
        if (i_cmd.push) dl_mem[b_dec] <= r_x;
        if (i_cmd.uwr) cf_mem[r_k[AW-1:0]] <= cf_new;
        r_dq <= dl_mem[dl_addr];
        r_cq <= cf_mem[cf_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= nafir_pkg::RST_TAP_COUNT;
            r_rate      <= nafir_pkg::RST_LEARNING_RATE;
            r_norm      <= nafir_pkg::RST_NORMALIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nafir_pkg::CFG_TAP_COUNT:     r_tap_count <= i_cfg_data[6:0];
                nafir_pkg::CFG_LEARNING_RATE: r_rate      <= i_cfg_data;
                nafir_pkg::CFG_NORMALIZE:     r_norm      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_b <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_k <= (r_k == CW'(TAPS - 1)) ? '0 : r_k + 1'b1;
                r_b <= '0;
            end
            if (i_cmd.push) begin
                r_b <= b_dec;
                r_k <= '0;
            end
            if (i_cmd.acc || i_cmd.uwr) r_k <= r_k + 1'b1;
            if (i_cmd.err) r_k <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_in_data.sample;
            r_d   <= i_in_data.desired;
            r_idx <= i_in_data.tap_index;
            r_n   <= n_clamp;
        end
        if (i_cmd.push) begin
            r_acc_y <= '0;
            r_acc_e <= '0;
        end
        if (i_cmd.mul) begin
            r_py <= nafir_pkg::qmul(r_cq, r_dq);
            r_pe <= nafir_pkg::qmul(r_dq, r_dq);
        end
        if (i_cmd.acc) begin
            r_acc_y <= r_acc_y + ACCW'(r_py);
            r_acc_e <= r_acc_e + ACCW'(r_pe);
        end
        if (i_cmd.err) begin
            r_y  <= y_sat;
            r_e  <= e_sat;
            r_en <= (en_sat == '0) ? 16'sd1 : en_sat;
        end
        if (i_cmd.um1) r_p1 <= nafir_pkg::qmul(r_dq, r_e);
        if (i_cmd.um2) r_upd <= nafir_pkg::qmul($signed({1'b0, r_rate}), r_p1);
        // restoring divide of |upd| * 2^15 by energy, one quotient bit a cycle
        if (i_cmd.div_init) begin
            r_sgn <= r_upd[15];
            r_sat <= (upd_abs >= {1'b0, r_en});
            r_rem <= upd_abs;
            r_q   <= '0;
            r_dc  <= 4'(nafir_pkg::DIV_STEPS);
        end
        if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_en}) begin
                r_rem <= rem_sh - {1'b0, r_en};
                r_q   <= {r_q[13:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[13:0], 1'b0};
            end
            r_dc <= r_dc - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_adapt || i_cmd.out_read) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_adapt) begin
            r_out.filter_output <= r_y;
            r_out.error_out     <= r_e;
            r_out.tap_value     <= '0;
        end else if (i_cmd.out_read) begin
            r_out.filter_output <= '0;
            r_out.error_out     <= '0;
            r_out.tap_value     <= idx_ok ? r_cq : 16'sd0;
        end
    end

    assign o_sts.clr_last  = (r_k == CW'(TAPS - 1));
    assign o_sts.k_done    = (r_k == r_n);
    assign o_sts.div_last  = (r_dc == 4'd1);
    assign o_sts.out_busy  = r_out_vld && i_out_stall;
    assign o_sts.normalize = r_norm;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

### sv/nlms_adaptive_fir_unit.sv
// top level of the q15 nlms adaptive fir filter
// One request at a time. A read request reads its tap and then waits in
// S_RDONE until the result register is free before its result is loaded. An
// adapt request runs a filter pass and then an update pass over the n active
// taps, one tap per step; with normalize set, the restoring divider scales
// each tap's update by the input energy. After reset a clearing pass zeroes
// both memories, and requests are stalled meanwhile; configuration writes are
// taken at any time but must only be issued while the block is idle. The
// result register lets a new request be accepted while the last result is
// still waiting to be taken.
`default_nettype none
module nlms_adaptive_fir_unit #(
    parameter int TAPS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // request channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  nafir_pkg::t_in_item  i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output nafir_pkg::t_out_item o_out_data,
    // configuration write port
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_idx,
    input  wire [14:0]           i_cfg_data
);

    nafir_pkg::t_cmd cmd;
    nafir_pkg::t_sts sts;
    logic            busy;

    // sequencer: owns every decision, the datapath only executes commands
    nafir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // tap memories, arithmetic and result register
    nafir_dpath #(
        .TAPS (TAPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a request is only taken in the idle state
    assign o_in_stall = busy;

endmodule
`default_nettype wire

### sv/nafir_checker.sv
// port-level checker for the nlms adaptive fir and its bind
`default_nettype none
module nafir_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input nafir_pkg::t_in_item  i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input nafir_pkg::t_out_item o_out_data,
    input wire                  i_cfg_we,
    input wire [1:0]            i_cfg_idx,
    input wire [14:0]           i_cfg_data
);

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy next cycle");

    // a result is either a read result or an adapt result, never a mix
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.tap_value == 16'sd0 ||
                        (o_out_data.filter_output == 16'sd0 &&
                         o_out_data.error_out == 16'sd0)))
        else $error("result mixes tap value with filter output");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

endmodule

bind nlms_adaptive_fir_unit nafir_checker u_nafir_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// testbench for the q15 nlms adaptive fir unit: directed table, then random requests
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int TAPS = 64;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    nafir_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    nafir_pkg::t_out_item o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = nafir_pkg::CFG_TAP_COUNT;
    logic [14:0]          i_cfg_data = '0;

    nlms_adaptive_fir_unit #(.TAPS(TAPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // filter state mirrored in the testbench
    logic signed [15:0] hist[TAPS];
    logic signed [15:0] coef[TAPS];
    int unsigned        mir_taps;
    int unsigned        mir_mu;
    int unsigned        mir_norm;

    nafir_pkg::t_out_item expected_results[$];
    int        mismatches = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // q15 product with floor rounding
    function automatic longint q15_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clip16(p >>> 15);
    endfunction

    // runs one request through the mirrored filter and returns its result
    function automatic nafir_pkg::t_out_item filter_step(nafir_pkg::t_in_item it);
        nafir_pkg::t_out_item r;
        int        n;
        longint    acc, y, e, nrg, upd;
        r = '0;
        if (it.op == nafir_pkg::OP_READ) begin
            r.tap_value = coef[it.tap_index];
            return r;
        end
        n = (mir_taps < 1) ? 1 : (mir_taps > TAPS) ? TAPS : int'(mir_taps);
        for (int k = TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = it.sample;
        acc = 0;
        for (int k = 0; k < n; k++) acc += q15_mul(longint'(coef[k]), longint'(hist[k]));
        y = clip16(acc);
        e = clip16(longint'(it.desired) - y);
        acc = 0;
        for (int k = 0; k < n; k++) acc += q15_mul(longint'(hist[k]), longint'(hist[k]));
        nrg = clip16(acc);
        if (nrg == 0) nrg = 1;
        for (int k = 0; k < n; k++) begin
            upd = q15_mul(longint'(mir_mu), q15_mul(longint'(hist[k]), e));
            if (mir_norm != 0) upd = clip16((upd * 32768) / nrg);
            coef[k] = 16'(clip16(longint'(coef[k]) + upd));
        end
        r.filter_output = 16'(y);
        r.error_out = 16'(e);
        return r;
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        nafir_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (want.filter_output !== o_out_data.filter_output ||
                    want.error_out !== o_out_data.error_out ||
                    want.tap_value !== o_out_data.tap_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: y %0d/%0d e %0d/%0d tap %0d/%0d (exp/got)",
                                 want.filter_output, o_out_data.filter_output,
                                 want.error_out, o_out_data.error_out,
                                 want.tap_value, o_out_data.tap_value);
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // one request: hold valid until it is taken, then maybe idle a while
    task automatic send_request(nafir_pkg::t_in_item it, bit typed,
                                nafir_pkg::t_out_item typed_res);
        nafir_pkg::t_out_item pred;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pred = filter_step(it);
        expected_results.push_back(typed ? typed_res : pred);
        if ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
    endtask

    // configuration only goes in while nothing is in flight
    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nafir_pkg::CFG_TAP_COUNT:     mir_taps = 32'(val[6:0]);
            nafir_pkg::CFG_LEARNING_RATE: mir_mu   = 32'(val[14:0]);
            nafir_pkg::CFG_NORMALIZE:     mir_norm = 32'(val[0]);
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            4: return 16'($urandom_range(511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    typedef struct {
        logic                 op;
        logic signed [15:0]   x;
        logic signed [15:0]   d;
        logic [5:0]           idx;
        bit                   typed;
        nafir_pkg::t_out_item res;
    } t_row;

    // directed rows; expectations typed where they follow from reset state
    t_row rows[] = '{
        '{nafir_pkg::OP_READ,  16'sh0000, 16'sh0000, 6'd0,  1, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'sh7FFF, 16'sh8000, 6'd63, 1, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh7FFF, 16'sh8000, 6'd0,  1, '{16'sh0, 16'sh8000, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'sh0000, 16'sh0000, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh8000, 16'sh7FFF, 6'd63, 0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh0000, 16'sh0000, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'shFFFF, 16'sh0001, 6'd42, 0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh0001, 16'shFFFF, 6'd21, 0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'sh5555, 16'shAAAA, 6'd1,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh3039, 16'shA460, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh8000, 16'sh8000, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'sh7FFF, 16'sh7FFF, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_ADAPT, 16'shAAAA, 16'sh5555, 6'd0,  0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'shFFFF, 16'shFFFF, 6'd42, 0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'sh0000, 16'sh0000, 6'd21, 0, '{16'sh0, 16'sh0, 16'sh0}},
        '{nafir_pkg::OP_READ,  16'sh0000, 16'sh0000, 6'd2,  0, '{16'sh0, 16'sh0, 16'sh0}}
    };

    typedef struct {
        int taps;
        int mu;
        int norm;
        int count;
    } t_phase;

    // tap count zero and above range, zero learning rate, both normalize modes
    t_phase phases[] = '{
        '{0,   32767, 1, 150},
        '{127, 1,     0, 40},
        '{3,   0,     1, 150},
        '{8,   16384, 0, 300},
        '{5,   3,     1, 300},
        '{64,  32767, 1, 20},
        '{2,   2000,  1, 300},
        '{16,  500,   0, 300},
        '{1,   32767, 0, 140}
    };

    initial begin
        nafir_pkg::t_in_item  it;
        nafir_pkg::t_out_item none;
        none = '0;
        for (int k = 0; k < TAPS; k++) begin
            hist[k] = '0;
            coef[k] = '0;
        end
        mir_taps = 32'(nafir_pkg::RST_TAP_COUNT);
        mir_mu   = 32'(nafir_pkg::RST_LEARNING_RATE);
        mir_norm = 32'(nafir_pkg::RST_NORMALIZE);
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 30;
        rx_idle_pct = 49;
        foreach (rows[r]) begin
            it.op = rows[r].op;
            it.sample = rows[r].x;
            it.desired = rows[r].d;
            it.tap_index = rows[r].idx;
            send_request(it, rows[r].typed, rows[r].res);
        end

        foreach (phases[p]) begin
            // sender then receiver idle first, then swapped, then none
            if (p < 3) begin
                tx_idle_pct = 30; rx_idle_pct = 49;
            end else if (p < 6) begin
                tx_idle_pct = 49; rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            write_reg(nafir_pkg::CFG_TAP_COUNT, 15'(phases[p].taps));
            write_reg(nafir_pkg::CFG_LEARNING_RATE, 15'(phases[p].mu));
            write_reg(nafir_pkg::CFG_NORMALIZE, 15'(phases[p].norm));
            for (int i = 0; i < phases[p].count; i++) begin
                it.op = ($urandom_range(99) < 80) ? nafir_pkg::OP_ADAPT : nafir_pkg::OP_READ;
                it.sample = pick_value();
                it.desired = pick_value();
                it.tap_index = 6'($urandom_range(63));
                send_request(it, 0, none);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
